// ===== sv/assert_macros.svh =====
// Assertion helpers. They expect clk and arst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication that checks the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/sbcc_pkg.sv =====
package sbcc_pkg;

	localparam int unsigned TIME_W     = 31;
	localparam int unsigned LIMIT_W    = 8;
	localparam int unsigned RETRY_W    = 12;
	localparam int unsigned CREDIT_W   = 10;
	localparam int unsigned RESULT_W   = 3;
	localparam int unsigned JITTER_W   = 3;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 12;

	localparam int unsigned FRAC_BITS_DEF = 4;
	localparam int unsigned STALE_SECONDS = 300;

	localparam logic MODE_QUERY  = 1'b0;
	localparam logic MODE_RECORD = 1'b1;

	localparam logic [JITTER_W-1:0] JITTER_MAX = JITTER_W'(4);

	localparam logic [LIMIT_W-1:0]  NET_FAIL_LIMIT_RST   = LIMIT_W'(60);
	localparam logic [RETRY_W-1:0]  NET_RETRY_BASE_RST   = RETRY_W'(300);
	localparam logic [RETRY_W-1:0]  NET_RETRY_MAX_RST    = RETRY_W'(3600);
	localparam logic [LIMIT_W-1:0]  QUOTA_FAIL_LIMIT_RST = LIMIT_W'(1);
	localparam logic [RETRY_W-1:0]  QUOTA_RETRY_BASE_RST = RETRY_W'(3);
	localparam logic [RETRY_W-1:0]  QUOTA_RETRY_MAX_RST  = RETRY_W'(60);
	localparam logic [CREDIT_W-1:0] CONC_MAX_RST         = CREDIT_W'(512);
	localparam logic [CREDIT_W-1:0] CONC_TRIGGER_RST     = CREDIT_W'(256);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NET_FAIL_LIMIT   = 3'd0,
		REG_NET_RETRY_BASE   = 3'd1,
		REG_NET_RETRY_MAX    = 3'd2,
		REG_QUOTA_FAIL_LIMIT = 3'd3,
		REG_QUOTA_RETRY_BASE = 3'd4,
		REG_QUOTA_RETRY_MAX  = 3'd5,
		REG_CONC_MAX         = 3'd6,
		REG_CONC_TRIGGER     = 3'd7
	} cfg_reg_t;

	typedef enum logic [RESULT_W-1:0] {
		RES_OK         = 3'd0,
		RES_DISCARD    = 3'd1,
		RES_NET_FAIL   = 3'd2,
		RES_QUOTA_FAIL = 3'd3,
		RES_OTHER      = 3'd4
	} send_result_t;

	typedef struct packed {
		logic [LIMIT_W-1:0]  net_fail_limit;
		logic [RETRY_W-1:0]  net_retry_base;
		logic [RETRY_W-1:0]  net_retry_max;
		logic [LIMIT_W-1:0]  quota_fail_limit;
		logic [RETRY_W-1:0]  quota_retry_base;
		logic [RETRY_W-1:0]  quota_retry_max;
		logic [CREDIT_W-1:0] concurrency_max;
		logic [CREDIT_W-1:0] concurrency_trigger;
	} cfg_t;

endpackage

// ===== sv/sbcc_if.sv =====
interface sbcc_in_if import sbcc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                mode;
	logic [TIME_W-1:0]   now_seconds;
	logic [RESULT_W-1:0] send_result;
	logic [JITTER_W-1:0] jitter;

	modport source (output valid, mode, now_seconds, send_result, jitter, input ready);
	modport sink (input valid, mode, now_seconds, send_result, jitter, output ready);
endinterface

interface sbcc_out_if import sbcc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                can_send;
	logic                credit_ok;
	logic                below_trigger;
	logic                was_disabled;
	logic [CREDIT_W-1:0] credit;

	modport source (output valid, can_send, credit_ok, below_trigger, was_disabled, credit,
		input ready);
	modport sink (input valid, can_send, credit_ok, below_trigger, was_disabled, credit,
		output ready);
endinterface

// ===== sv/sbcc_cfg.sv =====
module sbcc_cfg import sbcc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  we,
	input  logic [CFG_IDX_W-1:0]  index,
	input  logic [CFG_DATA_W-1:0] data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.net_fail_limit      <= NET_FAIL_LIMIT_RST;
			cfg_q.net_retry_base      <= NET_RETRY_BASE_RST;
			cfg_q.net_retry_max       <= NET_RETRY_MAX_RST;
			cfg_q.quota_fail_limit    <= QUOTA_FAIL_LIMIT_RST;
			cfg_q.quota_retry_base    <= QUOTA_RETRY_BASE_RST;
			cfg_q.quota_retry_max     <= QUOTA_RETRY_MAX_RST;
			cfg_q.concurrency_max     <= CONC_MAX_RST;
			cfg_q.concurrency_trigger <= CONC_TRIGGER_RST;
		end else if (we) begin
			unique case (cfg_reg_t'(index))
				REG_NET_FAIL_LIMIT:   cfg_q.net_fail_limit      <= data[LIMIT_W-1:0];
				REG_NET_RETRY_BASE:   cfg_q.net_retry_base      <= data[RETRY_W-1:0];
				REG_NET_RETRY_MAX:    cfg_q.net_retry_max       <= data[RETRY_W-1:0];
				REG_QUOTA_FAIL_LIMIT: cfg_q.quota_fail_limit    <= data[LIMIT_W-1:0];
				REG_QUOTA_RETRY_BASE: cfg_q.quota_retry_base    <= data[RETRY_W-1:0];
				REG_QUOTA_RETRY_MAX:  cfg_q.quota_retry_max     <= data[RETRY_W-1:0];
				REG_CONC_MAX:         cfg_q.concurrency_max     <= data[CREDIT_W-1:0];
				REG_CONC_TRIGGER:     cfg_q.concurrency_trigger <= data[CREDIT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== sv/sbcc_track.sv =====
module sbcc_track import sbcc_pkg::*; #(
	parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic [TIME_W-1:0]                   now,
	input  logic [TIME_W-1:0]                   err_time,
	input  logic [RETRY_W+FRAC_BITS:0]          interval,
	input  logic [RETRY_W+FRAC_BITS+1:0]        scaled,
	input  logic [RETRY_W-1:0]                  retry_max,
	output logic                                reached,
	output logic [RETRY_W+FRAC_BITS:0]          grown
);

	localparam int unsigned IV_W = RETRY_W + FRAC_BITS + 1;

	logic [TIME_W-1:0] diff;
	logic [TIME_W-1:0] whole_sec;
	logic [IV_W:0]     ceiling;

	// Wrapping difference; top bit set means the error time lies ahead.
	assign diff      = now - err_time;
	assign whole_sec = TIME_W'(interval[IV_W-1:FRAC_BITS]);
	assign reached   = !diff[TIME_W-1] && (diff >= whole_sec);

	assign ceiling = (IV_W+1)'({retry_max, {FRAC_BITS{1'b0}}});
	assign grown   = (scaled > ceiling) ? IV_W'(ceiling) : IV_W'(scaled);

endmodule

// ===== sv/sender_backoff_concurrency_ctrl.sv =====
// An accepted input beat passes the input register, then the result register, to its result beat.
// Throughput: one beat per cycle while results are taken; one state-update pass between registers.
// The input side keeps taking beats while a finished result waits, until both registers are full.
// Reset (arst_n low, asynchronous): both pipeline registers empty, tracks enabled with zero counts,
// intervals at the default bases, credit at the default maximum, config registers at defaults.
module sender_backoff_concurrency_ctrl import sbcc_pkg::*; #(
	parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	sbcc_in_if.sink               item,
	sbcc_out_if.source            result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "assert_macros.svh"

	// Interval width in fixed point: seconds field, fraction, one guard bit for base plus jitter.
	localparam int unsigned IV_W = RETRY_W + FRAC_BITS + 1;

	localparam logic [IV_W-1:0] NET_IV_RST   = IV_W'(NET_RETRY_BASE_RST) << FRAC_BITS;
	localparam logic [IV_W-1:0] QUOTA_IV_RST = IV_W'(QUOTA_RETRY_BASE_RST) << FRAC_BITS;
	localparam logic [TIME_W-1:0] STALE_LIMIT = TIME_W'(STALE_SECONDS);

	cfg_t cfg;

	sbcc_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	// ---------------------------------------------------------------
	// Input register
	// ---------------------------------------------------------------
	logic                item_valid_s1;
	logic                mode_s1;
	logic [TIME_W-1:0]   now_s1;
	logic [RESULT_W-1:0] result_s1;
	logic [JITTER_W-1:0] jitter_s1;

	logic out_valid_s2;
	logic advance;

	// The stage-1 beat moves on when the result register is empty or drains this cycle.
	assign advance    = item_valid_s1 && (!out_valid_s2 || result.ready);
	assign item.ready = !item_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (item.ready) begin
			item_valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			mode_s1   <= item.mode;
			now_s1    <= item.now_seconds;
			result_s1 <= item.send_result;
			jitter_s1 <= item.jitter;
		end
	end

	// ---------------------------------------------------------------
	// Per-destination state
	// ---------------------------------------------------------------
	logic [LIMIT_W-1:0]  net_cnt_q,     net_cnt_d;
	logic [LIMIT_W-1:0]  quota_cnt_q,   quota_cnt_d;
	logic [TIME_W-1:0]   net_time_q,    net_time_d;
	logic [TIME_W-1:0]   quota_time_q,  quota_time_d;
	logic [IV_W-1:0]     net_iv_q,      net_iv_d;
	logic [IV_W-1:0]     quota_iv_q,    quota_iv_d;
	logic                net_en_q,      net_en_d;
	logic                quota_en_q,    quota_en_d;
	logic [CREDIT_W-1:0] credit_q,      credit_d;
	logic [TIME_W-1:0]   credit_time_q, credit_time_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			net_cnt_q     <= '0;
			quota_cnt_q   <= '0;
			net_time_q    <= '0;
			quota_time_q  <= '0;
			net_iv_q      <= NET_IV_RST;
			quota_iv_q    <= QUOTA_IV_RST;
			net_en_q      <= 1'b1;
			quota_en_q    <= 1'b1;
			credit_q      <= CONC_MAX_RST;
			credit_time_q <= '0;
		end else if (advance) begin
			net_cnt_q     <= net_cnt_d;
			quota_cnt_q   <= quota_cnt_d;
			net_time_q    <= net_time_d;
			quota_time_q  <= quota_time_d;
			net_iv_q      <= net_iv_d;
			quota_iv_q    <= quota_iv_d;
			net_en_q      <= net_en_d;
			quota_en_q    <= quota_en_d;
			credit_q      <= credit_d;
			credit_time_q <= credit_time_d;
		end
	end

	// ---------------------------------------------------------------
	// Retry checks: network grows by 1.5, quota by 2, both clamped
	// ---------------------------------------------------------------
	logic [IV_W:0]   net_scaled;
	logic [IV_W:0]   quota_scaled;
	logic            net_reached;
	logic            quota_reached;
	logic [IV_W-1:0] net_grown;
	logic [IV_W-1:0] quota_grown;

	assign net_scaled   = {1'b0, net_iv_q} + (IV_W+1)'(net_iv_q >> 1);
	assign quota_scaled = {quota_iv_q, 1'b0};

	sbcc_track #(.FRAC_BITS(FRAC_BITS)) u_net_track (
		.now       (now_s1),
		.err_time  (net_time_q),
		.interval  (net_iv_q),
		.scaled    (net_scaled),
		.retry_max (cfg.net_retry_max),
		.reached   (net_reached),
		.grown     (net_grown)
	);

	sbcc_track #(.FRAC_BITS(FRAC_BITS)) u_quota_track (
		.now       (now_s1),
		.err_time  (quota_time_q),
		.interval  (quota_iv_q),
		.scaled    (quota_scaled),
		.retry_max (cfg.quota_retry_max),
		.reached   (quota_reached),
		.grown     (quota_grown)
	);

	// ---------------------------------------------------------------
	// Credit, failure counts and success reload values
	// ---------------------------------------------------------------
	logic                is_success;
	logic [CREDIT_W:0]   credit_sum;
	logic                credit_over;
	logic [TIME_W-1:0]   credit_age;
	logic                credit_stale;
	logic [LIMIT_W:0]    net_bump;
	logic [LIMIT_W:0]    quota_bump;
	logic                net_hit;
	logic                quota_hit;
	logic [JITTER_W-1:0] jitter_sat;
	logic [RETRY_W:0]    quota_base_sec;

	assign is_success  = (result_s1 == RES_OK) || (result_s1 == RES_DISCARD);
	assign credit_sum  = {1'b0, credit_q} + (is_success ? (CREDIT_W+1)'(2) : (CREDIT_W+1)'(1));
	assign credit_over = credit_sum > {1'b0, cfg.concurrency_max};

	// A zero credit left alone long enough comes back to one; a time ahead of us never counts.
	assign credit_age   = now_s1 - credit_time_q;
	assign credit_stale = (credit_q == '0) && !credit_age[TIME_W-1] && (credit_age > STALE_LIMIT);

	// Saturate the failure count at its limit; a zero limit trips on the first failure.
	assign net_bump   = {1'b0, net_cnt_q} + (LIMIT_W+1)'(1);
	assign quota_bump = {1'b0, quota_cnt_q} + (LIMIT_W+1)'(1);
	assign net_hit    = net_bump >= {1'b0, cfg.net_fail_limit};
	assign quota_hit  = quota_bump >= {1'b0, cfg.quota_fail_limit};

	assign jitter_sat     = (jitter_s1 > JITTER_MAX) ? JITTER_MAX : jitter_s1;
	assign quota_base_sec = {1'b0, cfg.quota_retry_base} + (RETRY_W+1)'(jitter_sat);

	logic                can_d;
	logic                cok_d;
	logic                below_d;
	logic                wasdis_d;

	always_comb begin
		net_cnt_d     = net_cnt_q;
		quota_cnt_d   = quota_cnt_q;
		net_time_d    = net_time_q;
		quota_time_d  = quota_time_q;
		net_iv_d      = net_iv_q;
		quota_iv_d    = quota_iv_q;
		net_en_d      = net_en_q;
		quota_en_d    = quota_en_q;
		credit_d      = credit_q;
		credit_time_d = credit_time_q;
		can_d         = 1'b0;
		cok_d         = 1'b0;
		below_d       = 1'b0;
		wasdis_d      = 1'b0;

		if (mode_s1 == MODE_QUERY) begin
			can_d = 1'b1;
			// Network track first; when it re-enables now the quota track waits for the next query.
			if (!net_en_q) begin
				if (net_reached) begin
					net_iv_d   = net_grown;
					net_time_d = now_s1;
					net_cnt_d  = '0;
					net_en_d   = 1'b1;
				end else begin
					can_d = 1'b0;
				end
			end else if (!quota_en_q) begin
				if (quota_reached) begin
					quota_iv_d   = quota_grown;
					quota_time_d = now_s1;
					quota_cnt_d  = '0;
					quota_en_d   = 1'b1;
				end else begin
					can_d = 1'b0;
				end
			end
			if (credit_stale) begin
				credit_d      = CREDIT_W'(1);
				credit_time_d = now_s1;
			end
			cok_d = credit_d != '0;
		end else begin
			wasdis_d = !(net_en_q && quota_en_q);
			case (result_s1) inside
				RES_OK, RES_DISCARD: begin
					// Success doubles as region recovery: reload both tracks.
					net_cnt_d   = '0;
					quota_cnt_d = '0;
					net_en_d    = 1'b1;
					quota_en_d  = 1'b1;
					net_iv_d    = IV_W'({cfg.net_retry_base, {FRAC_BITS{1'b0}}});
					quota_iv_d  = IV_W'({quota_base_sec, {FRAC_BITS{1'b0}}});
				end
				RES_NET_FAIL: begin
					net_time_d = now_s1;
					if (net_hit) begin
						net_cnt_d = cfg.net_fail_limit;
						net_en_d  = 1'b0;
					end else begin
						net_cnt_d = net_bump[LIMIT_W-1:0];
					end
				end
				RES_QUOTA_FAIL: begin
					quota_time_d = now_s1;
					if (quota_hit) begin
						quota_cnt_d = cfg.quota_fail_limit;
						quota_en_d  = 1'b0;
					end else begin
						quota_cnt_d = quota_bump[LIMIT_W-1:0];
					end
				end
				default: ;
			endcase

			// Credit: quota failure drops to one, everything else adds with saturation.
			if (result_s1 == RES_QUOTA_FAIL) begin
				credit_d      = CREDIT_W'(1);
				credit_time_d = now_s1;
			end else if (credit_over) begin
				credit_d = cfg.concurrency_max;
			end else begin
				credit_d      = credit_sum[CREDIT_W-1:0];
				credit_time_d = now_s1;
			end

			below_d = is_success && (credit_d < cfg.concurrency_trigger);
		end
	end

	// ---------------------------------------------------------------
	// Result register
	// ---------------------------------------------------------------
	logic                can_s2;
	logic                cok_s2;
	logic                below_s2;
	logic                wasdis_s2;
	logic [CREDIT_W-1:0] credit_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= 1'b1;
		end else if (result.ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			can_s2    <= can_d;
			cok_s2    <= cok_d;
			below_s2  <= below_d;
			wasdis_s2 <= wasdis_d;
			credit_s2 <= credit_d;
		end
	end

	assign result.valid         = out_valid_s2;
	assign result.can_send      = can_s2;
	assign result.credit_ok     = cok_s2;
	assign result.below_trigger = below_s2;
	assign result.was_disabled  = wasdis_s2;
	assign result.credit        = credit_s2;

	// ---------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------
	logic adv_record;

	assign adv_record = advance && (mode_s1 == MODE_RECORD);

	`ASSERT_IMPLY(a_ready_when_free, !out_valid_s2, item.ready, "input stalled with result slot free")
	`ASSERT_NEXT(a_quota_fail_credit, adv_record && (result_s1 == RES_QUOTA_FAIL),
		credit_q == CREDIT_W'(1), "quota failure did not drop credit to one")
	`ASSERT_IMPLY(a_net_disable_cause, $fell(net_en_q),
		$past(adv_record && (result_s1 == RES_NET_FAIL)), "network track disabled without a failure")
	`ASSERT_NEXT(a_credit_reported, advance, result.credit == credit_q,
		"reported credit differs from stored credit")

endmodule

// ===== bench/sender_backoff_concurrency_ctrl_tb.sv =====
`timescale 1ns / 100ps

module sender_backoff_concurrency_ctrl_tb;
	import sbcc_pkg::*;

	localparam int unsigned FRAC        = FRAC_BITS_DEF;
	localparam int unsigned CYCLE_LIMIT = 150000;
	localparam int unsigned LONG_STALL  = 200;
	localparam int unsigned PHASES      = 11;
	localparam int unsigned PHASE_BEATS = 76;

	// One send event as it travels on the input channel.
	typedef struct packed {
		logic                mode;
		logic [TIME_W-1:0]   now_s;
		logic [RESULT_W-1:0] res;
		logic [JITTER_W-1:0] jit;
	} send_event_t;

	// One gate status as it comes back on the result channel.
	typedef struct packed {
		logic                can_send;
		logic                credit_ok;
		logic                below_trigger;
		logic                was_disabled;
		logic [CREDIT_W-1:0] credit;
	} gate_status_t;

	logic clk;
	logic arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	sbcc_in_if  item_ch ();
	sbcc_out_if result_ch ();

	sender_backoff_concurrency_ctrl uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Stimulus and expectation stores.
	send_event_t  pending_events[$];
	gate_status_t expected_status[$];
	send_event_t  offered;

	// Flow control knobs, written by the stimulus process at the falling edge only.
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	bit          send_hold;
	bit          stall_req;

	// Receiver-side long-stall bookkeeping, owned by the receiver process.
	bit          stall_seen;
	int unsigned stall_left;

	int unsigned fail_count;
	int unsigned cycle_count;

	// Running wall clock for generated events.
	logic [TIME_W-1:0] clock_s;

	// Shadow of the gate: configuration and both backoff tracks plus the credit.
	cfg_t              gate_cfg;
	int unsigned       net_fails, quota_fails;
	logic [TIME_W-1:0] net_err_t, quota_err_t, credit_t;
	int unsigned       net_ivl, quota_ivl;
	bit                net_enabled, quota_enabled;
	int unsigned       credit_cnt;

	// ------------------------------------------------------------------
	// Gate behavior
	// ------------------------------------------------------------------

	// A track may retry once the wrapped, non-negative elapsed time reaches
	// the whole-second part of its interval.
	function automatic bit time_reached(logic [TIME_W-1:0] now_s, logic [TIME_W-1:0] t,
		int unsigned ivl);
		logic [TIME_W-1:0] d;
		d = now_s - t;
		return !d[TIME_W-1] && (d >= (ivl >> FRAC));
	endfunction

	function automatic int unsigned clamp_ivl(int unsigned q, logic [RETRY_W-1:0] max_s);
		int unsigned m;
		m = 32'(max_s) << FRAC;
		return (q > m) ? m : q;
	endfunction

	// Grow the credit; on saturation hold at the ceiling and keep the old update time.
	function automatic void credit_gain(int unsigned inc, logic [TIME_W-1:0] now_s);
		int unsigned c;
		c = credit_cnt + inc;
		if (c > gate_cfg.concurrency_max) begin
			credit_cnt = gate_cfg.concurrency_max;
		end else begin
			credit_cnt = c;
			credit_t   = now_s;
		end
	endfunction

	// Saturating failure count; reaching the limit disables the track.
	function automatic int unsigned fail_bump(int unsigned cnt, int unsigned lim,
		inout bit enabled);
		int unsigned c;
		c = cnt + 1;
		if (c >= lim) begin
			c       = lim;
			enabled = 1'b0;
		end
		return c;
	endfunction

	// Apply one event to the shadow state and return the status it produces.
	function automatic gate_status_t predict_gate(send_event_t ev);
		gate_status_t      st;
		int unsigned       jit;
		logic [TIME_W-1:0] d;
		st  = '0;
		jit = (ev.jit > JITTER_MAX) ? JITTER_MAX : ev.jit;
		if (ev.mode == MODE_QUERY) begin
			st.can_send = 1'b1;
			// Network track first; a re-enable here skips the quota track this beat.
			if (!net_enabled) begin
				if (time_reached(ev.now_s, net_err_t, net_ivl)) begin
					net_ivl     = clamp_ivl(net_ivl + (net_ivl >> 1), gate_cfg.net_retry_max);
					net_err_t   = ev.now_s;
					net_fails   = 0;
					net_enabled = 1'b1;
				end else begin
					st.can_send = 1'b0;
				end
			end else if (!quota_enabled) begin
				if (time_reached(ev.now_s, quota_err_t, quota_ivl)) begin
					quota_ivl     = clamp_ivl(quota_ivl << 1, gate_cfg.quota_retry_max);
					quota_err_t   = ev.now_s;
					quota_fails   = 0;
					quota_enabled = 1'b1;
				end else begin
					st.can_send = 1'b0;
				end
			end
			// Stale zero credit recovers to one.
			if (credit_cnt == 0) begin
				d = ev.now_s - credit_t;
				if (!d[TIME_W-1] && d > STALE_SECONDS) begin
					credit_cnt = 1;
					credit_t   = ev.now_s;
				end
			end
			st.credit_ok = (credit_cnt != 0);
		end else begin
			st.was_disabled = !(net_enabled && quota_enabled);
			case (ev.res)
				RES_OK, RES_DISCARD: begin
					net_fails     = 0;
					quota_fails   = 0;
					net_enabled   = 1'b1;
					quota_enabled = 1'b1;
					net_ivl       = 32'(gate_cfg.net_retry_base) << FRAC;
					quota_ivl     = (32'(gate_cfg.quota_retry_base) + jit) << FRAC;
					credit_gain(2, ev.now_s);
					st.below_trigger = (credit_cnt < gate_cfg.concurrency_trigger);
				end
				RES_NET_FAIL: begin
					net_err_t = ev.now_s;
					credit_gain(1, ev.now_s);
					net_fails = fail_bump(net_fails, gate_cfg.net_fail_limit, net_enabled);
				end
				RES_QUOTA_FAIL: begin
					quota_err_t = ev.now_s;
					credit_cnt  = 1;
					credit_t    = ev.now_s;
					quota_fails = fail_bump(quota_fails, gate_cfg.quota_fail_limit, quota_enabled);
				end
				default: begin
					credit_gain(1, ev.now_s);
				end
			endcase
		end
		st.credit = CREDIT_W'(credit_cnt);
		return st;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic void push_event(logic mode, logic [TIME_W-1:0] now_s,
		logic [RESULT_W-1:0] res, logic [JITTER_W-1:0] jit);
		pending_events.push_back('{mode: mode, now_s: now_s, res: res, jit: jit});
	endfunction

	// Mostly small forward steps so retry windows open and close; now and
	// then a long jump, a step back in time, or a fresh random point.
	function automatic send_event_t rand_event();
		send_event_t ev;
		int unsigned r;
		r = $urandom_range(99);
		if (r < 70)
			clock_s = TIME_W'(clock_s + $urandom_range(0, 6));
		else if (r < 88)
			clock_s = TIME_W'(clock_s + $urandom_range(0, 300));
		else if (r < 95)
			clock_s = TIME_W'(clock_s + $urandom_range(0, 5000));
		else if (r < 98)
			clock_s = TIME_W'(clock_s - $urandom_range(1, 100));
		else
			clock_s = TIME_W'($urandom);
		ev.now_s = clock_s;
		ev.mode  = ($urandom_range(99) < 45) ? MODE_QUERY : MODE_RECORD;
		r = $urandom_range(99);
		if (r < 12)
			ev.res = RES_OK;
		else if (r < 20)
			ev.res = RES_DISCARD;
		else if (r < 55)
			ev.res = RES_NET_FAIL;
		else if (r < 80)
			ev.res = RES_QUOTA_FAIL;
		else
			ev.res = RES_OTHER;
		ev.jit = JITTER_W'($urandom_range(0, 4));
		return ev;
	endfunction

	function automatic logic [RETRY_W-1:0] pick_secs();
		return ($urandom_range(4) == 0) ? RETRY_W'($urandom_range(1, 4095))
			: RETRY_W'($urandom_range(1, 25));
	endfunction

	// First four phases use fixed settings that include the extremes; later ones draw mostly short limits.
	function automatic cfg_t phase_settings(int unsigned ph);
		cfg_t s;
		case (ph)
			0: s = '{net_fail_limit: 2, net_retry_base: 4, net_retry_max: 20,
				quota_fail_limit: 1, quota_retry_base: 1, quota_retry_max: 8,
				concurrency_max: 20, concurrency_trigger: 10};
			1: s = '{net_fail_limit: 1, net_retry_base: 1, net_retry_max: 1,
				quota_fail_limit: 255, quota_retry_base: 4095, quota_retry_max: 4095,
				concurrency_max: 1, concurrency_trigger: 0};
			2: s = '{net_fail_limit: 255, net_retry_base: 4095, net_retry_max: 4095,
				quota_fail_limit: 3, quota_retry_base: 1, quota_retry_max: 1,
				concurrency_max: 1023, concurrency_trigger: 1023};
			3: s = '{net_fail_limit: 3, net_retry_base: 10, net_retry_max: 4095,
				quota_fail_limit: 2, quota_retry_base: 5, quota_retry_max: 60,
				concurrency_max: 300, concurrency_trigger: 256};
			default: begin
				s.net_fail_limit = ($urandom_range(3) == 0) ? LIMIT_W'($urandom_range(1, 255))
					: LIMIT_W'($urandom_range(1, 5));
				s.quota_fail_limit = ($urandom_range(3) == 0) ? LIMIT_W'($urandom_range(1, 255))
					: LIMIT_W'($urandom_range(1, 5));
				s.net_retry_base   = pick_secs();
				s.net_retry_max    = pick_secs();
				s.quota_retry_base = pick_secs();
				s.quota_retry_max  = pick_secs();
				s.concurrency_max = ($urandom_range(3) == 0) ? CREDIT_W'($urandom_range(1, 1023))
					: CREDIT_W'($urandom_range(1, 40));
				s.concurrency_trigger = ($urandom_range(3) == 0)
					? CREDIT_W'($urandom_range(0, 1023)) : CREDIT_W'($urandom_range(0, 45));
			end
		endcase
		return s;
	endfunction

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
	endtask

	// Write every register back to back, then mirror the new setting.
	task automatic apply_settings(cfg_t s);
		write_reg(REG_NET_FAIL_LIMIT, CFG_DATA_W'(s.net_fail_limit));
		write_reg(REG_NET_RETRY_BASE, s.net_retry_base);
		write_reg(REG_NET_RETRY_MAX, s.net_retry_max);
		write_reg(REG_QUOTA_FAIL_LIMIT, CFG_DATA_W'(s.quota_fail_limit));
		write_reg(REG_QUOTA_RETRY_BASE, s.quota_retry_base);
		write_reg(REG_QUOTA_RETRY_MAX, s.quota_retry_max);
		write_reg(REG_CONC_MAX, CFG_DATA_W'(s.concurrency_max));
		write_reg(REG_CONC_TRIGGER, CFG_DATA_W'(s.concurrency_trigger));
		@(posedge clk);
		cfg_we   <= 1'b0;
		gate_cfg  = s;
		@(negedge clk);
	endtask

	// Block until every queued beat went in and every status came back,
	// then let the pipeline settle.
	task automatic wait_drained();
		do @(negedge clk);
		while (pending_events.size() != 0 || item_ch.valid || expected_status.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// Clock
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Input driver: offer the next pending event, hold it until the beat
	// is taken, and predict its status at the accepting edge.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
		end else begin
			if (item_ch.valid && item_ch.ready)
				expected_status.push_back(predict_gate(offered));
			// Advance only when nothing is on the bus or the current beat was taken.
			if (!item_ch.valid || item_ch.ready) begin
				if (pending_events.size() != 0 && !send_hold
					&& $urandom_range(99) >= send_idle_pct) begin
					offered = pending_events.pop_front();
					item_ch.valid       <= 1'b1;
					item_ch.mode        <= offered.mode;
					item_ch.now_seconds <= offered.now_s;
					item_ch.send_result <= offered.res;
					item_ch.jitter      <= offered.jit;
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result receiver: random back-pressure, plus a long hold whenever the
	// stimulus process flips its request toggle.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			stall_seen       = 1'b0;
			stall_left       = 0;
		end else begin
			if (stall_seen != stall_req) begin
				stall_seen = stall_req;
				stall_left = LONG_STALL;
			end
			if (stall_left != 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// ------------------------------------------------------------------
	// Result monitor: compare each status beat against the oldest prediction.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		gate_status_t want;
		bit           bad;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_status.size() == 0) begin
				if (fail_count < 10)
					$display("unexpected status beat: can=%0b ok=%0b below=%0b dis=%0b credit=%0d",
						result_ch.can_send, result_ch.credit_ok, result_ch.below_trigger,
						result_ch.was_disabled, result_ch.credit);
				fail_count++;
			end else begin
				want = expected_status.pop_front();
				bad  = (result_ch.can_send !== want.can_send)
					|| (result_ch.credit_ok !== want.credit_ok)
					|| (result_ch.below_trigger !== want.below_trigger)
					|| (result_ch.was_disabled !== want.was_disabled)
					|| (result_ch.credit !== want.credit);
				if (bad) begin
					if (fail_count < 10)
						$display("status mismatch: expected can=%0b ok=%0b below=%0b dis=%0b credit=%0d, got can=%0b ok=%0b below=%0b dis=%0b credit=%0d",
							want.can_send, want.credit_ok, want.below_trigger,
							want.was_disabled, want.credit,
							result_ch.can_send, result_ch.credit_ok, result_ch.below_trigger,
							result_ch.was_disabled, result_ch.credit);
					fail_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: drop the run if it overstays its cycle budget.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("sender_backoff_concurrency_ctrl_tb: FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus sequence
	// ------------------------------------------------------------------
	initial begin : stimulus
		int unsigned ph;

		// Known values on every input from time zero.
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = REG_NET_FAIL_LIMIT;
		cfg_data            = '0;
		item_ch.valid       = 1'b0;
		item_ch.mode        = MODE_QUERY;
		item_ch.now_seconds = '0;
		item_ch.send_result = RES_OK;
		item_ch.jitter      = '0;
		result_ch.ready     = 1'b0;
		send_idle_pct       = 0;
		recv_stall_pct      = 0;
		send_hold           = 1'b0;
		stall_req           = 1'b0;
		fail_count          = 0;
		cycle_count         = 0;
		clock_s             = '0;

		// Shadow state at reset.
		gate_cfg = '{net_fail_limit: NET_FAIL_LIMIT_RST, net_retry_base: NET_RETRY_BASE_RST,
			net_retry_max: NET_RETRY_MAX_RST, quota_fail_limit: QUOTA_FAIL_LIMIT_RST,
			quota_retry_base: QUOTA_RETRY_BASE_RST, quota_retry_max: QUOTA_RETRY_MAX_RST,
			concurrency_max: CONC_MAX_RST, concurrency_trigger: CONC_TRIGGER_RST};
		net_fails     = 0;
		quota_fails   = 0;
		net_err_t     = '0;
		quota_err_t   = '0;
		credit_t      = '0;
		net_ivl       = 32'(NET_RETRY_BASE_RST) << FRAC;
		quota_ivl     = 32'(QUOTA_RETRY_BASE_RST) << FRAC;
		net_enabled   = 1'b1;
		quota_enabled = 1'b1;
		credit_cnt    = CONC_MAX_RST;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed beats at the reset setting: credit saturation, quota lockout
		// and its retry window, interval doubling, the top of the time range,
		// wrap through zero, and a step back in time.
		push_event(MODE_QUERY, 0, RES_OK, 0);
		push_event(MODE_RECORD, 0, RES_OK, 0);
		push_event(MODE_RECORD, 1, RES_DISCARD, 4);
		push_event(MODE_RECORD, 5, RES_QUOTA_FAIL, 0);
		push_event(MODE_QUERY, 6, RES_OTHER, 3);
		push_event(MODE_RECORD, 7, RES_OTHER, 1);
		push_event(MODE_RECORD, 8, RES_NET_FAIL, 2);
		push_event(MODE_QUERY, 12, RES_OK, 0);
		push_event(MODE_RECORD, 13, RES_QUOTA_FAIL, 4);
		push_event(MODE_QUERY, 26, RES_NET_FAIL, 0);
		push_event(MODE_QUERY, 27, RES_OK, 0);
		push_event(MODE_RECORD, 27, RES_OK, 2);
		push_event(MODE_QUERY, {TIME_W{1'b1}}, RES_QUOTA_FAIL, 4);
		push_event(MODE_RECORD, {TIME_W{1'b1}}, RES_QUOTA_FAIL, 0);
		push_event(MODE_QUERY, 0, RES_OK, 0);
		push_event(MODE_QUERY, 100, RES_OK, 0);
		push_event(MODE_RECORD, 200, RES_QUOTA_FAIL, 1);
		push_event(MODE_QUERY, 150, RES_OK, 0);
		push_event(MODE_RECORD, 150, RES_DISCARD, 3);
		push_event(MODE_RECORD, 151, RES_NET_FAIL, 4);
		push_event(MODE_QUERY, TIME_W'(32'h4000_0000), RES_OTHER, 4);
		clock_s = TIME_W'(32'h4000_0000);
		wait_drained();

		// Random phases, each with its own register setting and flow pattern.
		for (ph = 0; ph < PHASES; ph++) begin
			apply_settings(phase_settings(ph));
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
				default: begin send_idle_pct = 9; recv_stall_pct = 9; end
			endcase
			// Keep the sender busy while the receiver holds off, so the block backs up.
			if (ph == 5)
				send_idle_pct = 0;
			repeat (PHASE_BEATS) pending_events.push_back(rand_event());

			if (ph == 4) begin
				// Pause the sender halfway until every outstanding status is back.
				do @(negedge clk);
				while (pending_events.size() >= PHASE_BEATS / 2);
				send_hold = 1'b1;
				do @(negedge clk);
				while (item_ch.valid || expected_status.size() != 0);
				send_hold = 1'b0;
			end
			if (ph == 5)
				stall_req = ~stall_req;
			wait_drained();
		end

		repeat (8) @(posedge clk);
		if (fail_count == 0 && expected_status.size() == 0)
			$display("sender_backoff_concurrency_ctrl_tb: PASS");
		else
			$display("sender_backoff_concurrency_ctrl_tb: FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+sv
sv/sbcc_pkg.sv
sv/sbcc_if.sv
sv/sbcc_cfg.sv
sv/sbcc_track.sv
sv/sender_backoff_concurrency_ctrl.sv
bench/sender_backoff_concurrency_ctrl_tb.sv
